// ===== sv/sequence_reorder_merger_assert.svh =====
// assertion macros for the sequence reorder merger
// expects clk and rst in the scope where they are used
`ifndef SEQUENCE_REORDER_MERGER_ASSERT_SVH
`define SEQUENCE_REORDER_MERGER_ASSERT_SVH

// condition implies consequence in the same cycle
`define SRM_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SRM_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/srm_pkg.sv =====
// shared types and constants of the sequence reorder merger
// no dependencies
`timescale 1ns / 1ps

package srm_pkg;

  localparam int WINDOW        = 16;
  localparam int SLOT_W        = $clog2(WINDOW);
  localparam int PAYLOAD_WIDTH = 32;
  localparam int PAY_KEEP      = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int ID_W          = 32;
  localparam int SRC_W         = 7;
  localparam logic [SRC_W-1:0] ENDS_MAX = 7'd127;
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_GAP    = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] id;
    logic [31:0] payload;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  typedef struct packed {
    logic draining;
    logic finished;
  } eng_status_t;

endpackage

// ===== sv/srm_if.sv =====
// channel interfaces of the sequence reorder merger
// depends on srm_pkg
`timescale 1ns / 1ps

interface srm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] seq_id;
  logic [31:0] payload;
  modport source (output valid, func, seq_id, payload, input ready);
  modport sink (input valid, func, seq_id, payload, output ready);
endinterface

interface srm_out_if;
  logic              valid;
  logic              ready;
  srm_pkg::kind_t    kind;
  logic [31:0]       out_id;
  logic [31:0]       out_payload;
  logic              last;
  modport source (output valid, kind, out_id, out_payload, last, input ready);
  modport sink (input valid, kind, out_id, out_payload, last, output ready);
endinterface

interface srm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [srm_pkg::SRC_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/srm_engine.sv =====
// front part: accepts items, classifies them, parks and drains the window
// depends on srm_pkg and srm_if
`timescale 1ns / 1ps

module srm_engine (
  input  logic                 clk,
  input  logic                 rst,
  srm_in_if.sink               items,
  srm_cfg_if.sink              cfg,
  input  logic                 full,
  output srm_pkg::push_t       push,
  output srm_pkg::eng_status_t status
);

  srm_pkg::state_t                 state, state_next;
  logic [srm_pkg::ID_W-1:0]        next_expected, next_expected_next;
  logic [srm_pkg::SLOT_W-1:0]      head, head_next;
  logic [srm_pkg::WINDOW-1:0]      slot_valid, slot_valid_next;
  logic [srm_pkg::SRC_W-1:0]       ends_seen, ends_seen_next;
  logic [srm_pkg::SRC_W-1:0]       source_count;
  logic                            finished, finished_next;
  logic [srm_pkg::PAY_KEEP-1:0]    slot_payload [srm_pkg::WINDOW];

  logic                            fire;
  logic [srm_pkg::ID_W-1:0]        delta;
  logic                            near;
  logic [srm_pkg::SLOT_W:0]        slot_sum;
  logic [srm_pkg::SLOT_W-1:0]      park_slot;
  logic [srm_pkg::SLOT_W-1:0]      head_inc;
  logic [srm_pkg::SRC_W-1:0]       ends_inc;
  logic                            mem_we;

  assign items.ready = (state == srm_pkg::ST_IDLE) && !full;
  assign fire        = items.valid && items.ready;
  assign cfg.ready   = 1'b1;

  assign delta     = items.seq_id - next_expected;
  assign near      = delta < srm_pkg::ID_W'(srm_pkg::WINDOW);
  assign slot_sum  = {1'b0, head} + {1'b0, delta[srm_pkg::SLOT_W-1:0]};
  assign park_slot = (slot_sum >= (srm_pkg::SLOT_W+1)'(srm_pkg::WINDOW))
                     ? srm_pkg::SLOT_W'(slot_sum - (srm_pkg::SLOT_W+1)'(srm_pkg::WINDOW))
                     : slot_sum[srm_pkg::SLOT_W-1:0];
  assign head_inc  = (head == srm_pkg::SLOT_W'(srm_pkg::WINDOW - 1))
                     ? '0 : head + 1'b1;
  assign ends_inc  = (ends_seen == srm_pkg::ENDS_MAX) ? ends_seen : ends_seen + 1'b1;

  assign status.draining = (state == srm_pkg::ST_DRAIN);
  assign status.finished = finished;

  always_comb begin
    state_next         = state;
    next_expected_next = next_expected;
    head_next          = head;
    slot_valid_next    = slot_valid;
    ends_seen_next     = ends_seen;
    finished_next      = finished;
    mem_we             = 1'b0;
    push               = '0;
    push.res.id        = next_expected;
    push.res.last      = 1'b1;
    push.res.kind      = srm_pkg::KIND_REJECT;
    unique case (state)
      srm_pkg::ST_IDLE: begin
        if (fire) begin
          priority if (finished) begin
            push.valid = 1'b1;
          end else if (items.func) begin
            ends_seen_next = ends_inc;
            if (ends_inc >= source_count) begin
              finished_next = 1'b1;
              push.valid    = 1'b1;
              push.res.kind = (|slot_valid) ? srm_pkg::KIND_GAP : srm_pkg::KIND_DONE;
            end
          end else if (delta == '0) begin
            push.valid          = 1'b1;
            push.res.kind       = srm_pkg::KIND_DATA;
            push.res.id         = items.seq_id;
            push.res.payload    = 32'(items.payload[srm_pkg::PAY_KEEP-1:0]);
            push.res.last       = !slot_valid[head_inc];
            next_expected_next  = next_expected + 1'b1;
            head_next           = head_inc;
            if (slot_valid[head_inc]) begin
              state_next = srm_pkg::ST_DRAIN;
            end
          end else if (near && !slot_valid[park_slot]) begin
            slot_valid_next[park_slot] = 1'b1;
            mem_we                     = 1'b1;
          end else begin
            push.valid = 1'b1;
          end
        end
      end
      srm_pkg::ST_DRAIN: begin
        if (!full) begin
          push.valid            = 1'b1;
          push.res.kind         = srm_pkg::KIND_DATA;
          push.res.payload      = 32'(slot_payload[head]);
          push.res.last         = !slot_valid[head_inc];
          slot_valid_next[head] = 1'b0;
          next_expected_next    = next_expected + 1'b1;
          head_next             = head_inc;
          if (!slot_valid[head_inc]) begin
            state_next = srm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = srm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srm_pkg::ST_IDLE;
      next_expected <= '0;
      head          <= '0;
      slot_valid    <= '0;
      ends_seen     <= '0;
      finished      <= 1'b0;
      source_count  <= srm_pkg::SRC_W'(1);
    end else begin
      state         <= state_next;
      next_expected <= next_expected_next;
      head          <= head_next;
      slot_valid    <= slot_valid_next;
      ends_seen     <= ends_seen_next;
      finished      <= finished_next;
      if (cfg.valid) begin
        source_count <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_payload[park_slot] <= items.payload[srm_pkg::PAY_KEEP-1:0];
    end
  end

endmodule

// ===== sv/srm_queue.sv =====
// back part: short result queue that drives the output channel
// depends on srm_pkg and srm_if
`timescale 1ns / 1ps

module srm_queue (
  input  logic           clk,
  input  logic           rst,
  input  srm_pkg::push_t push,
  output logic           full,
  srm_out_if.source      results
);

  srm_pkg::result_t       entries [srm_pkg::QDEPTH];
  logic [srm_pkg::QAW-1:0] wptr, rptr;
  logic [srm_pkg::QAW:0]   count;
  logic                    do_push, do_pop;
  srm_pkg::result_t        head_res;

  assign full    = (count == (srm_pkg::QAW+1)'(srm_pkg::QDEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = results.valid && results.ready;

  assign head_res            = entries[rptr];
  assign results.valid       = (count != '0);
  assign results.kind        = head_res.kind;
  assign results.out_id      = head_res.id;
  assign results.out_payload = head_res.payload;
  assign results.last        = head_res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == srm_pkg::QAW'(srm_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == srm_pkg::QAW'(srm_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push.res;
    end
  end

endmodule

// ===== sv/sequence_reorder_merger.sv =====
// top level of the sequence reorder merger: engine plus result queue
// depends on srm_pkg, srm_if, srm_engine, srm_queue and the assertion header
//
// channel   dir   handshake     carries
// items     in    valid/ready   func, seq_id, payload
// results   out   valid/ready   kind, out_id, out_payload, last
// cfg       in    valid/ready   source_count, always ready
//
// an item is taken when it is ready; the parked items that it frees follow in order,
// as the drain walks the window one slot per cycle while the queue is not full
// the four-entry result queue lets the engine run ahead of a stalled output
// items are held off while draining or while the queue is full
// synchronous reset clears the window valid bits, counters and queue at once
`timescale 1ns / 1ps
`include "sequence_reorder_merger_assert.svh"

module sequence_reorder_merger (
  input  logic      clk,
  input  logic      rst,
  srm_in_if.sink    items,
  srm_out_if.source results,
  srm_cfg_if.sink   cfg
);

  srm_pkg::push_t       push;
  srm_pkg::eng_status_t status;
  logic                 full;

  srm_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .cfg    (cfg),
    .full   (full),
    .push   (push),
    .status (status)
  );

  srm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .results (results)
  );

  `SRM_ASSERT_NOW(a_no_push_full, push.valid, !full, "result pushed into a full queue")
  `SRM_ASSERT_NOW(a_hold_in_drain, status.draining, !items.ready, "item taken while draining")
  `SRM_ASSERT_NOW(a_reject_after_end, items.valid && items.ready && status.finished,
    push.valid && push.res.kind == srm_pkg::KIND_REJECT && push.res.last,
    "transfer after completion not rejected")
  `SRM_ASSERT_NEXT(a_drain_pushes, status.draining && !full, results.valid,
    "drain step gave no result")

endmodule

// ===== sim/srm_checker.sv =====
// result checker for the sequence reorder merger: predicts the released stream
// from the item and cfg transfers and compares every result transfer field by field
// depends on srm_pkg
`timescale 1ns / 1ps

module srm_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic                      func,
  input  logic [31:0]               seq_id,
  input  logic [31:0]               payload,
  input  logic                      res_valid,
  input  logic                      res_ready,
  input  srm_pkg::kind_t            kind,
  input  logic [31:0]               out_id,
  input  logic [31:0]               out_payload,
  input  logic                      last,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [srm_pkg::SRC_W-1:0] cfg_data,
  output int                        errors,
  output int                        pending
);

  logic [31:0]               next_id;
  logic [31:0]               parked_pay [srm_pkg::WINDOW];
  logic                      parked     [srm_pkg::WINDOW];
  logic [srm_pkg::SRC_W-1:0] ends_count;
  logic [srm_pkg::SRC_W-1:0] sources;
  logic                      done;
  srm_pkg::result_t          release_queue [$];
  srm_pkg::result_t          want;

  function automatic void queue_result(input srm_pkg::kind_t k, input logic [31:0] id,
                                       input logic [31:0] pay);
    srm_pkg::result_t r;
    r.kind    = k;
    r.id      = id;
    r.payload = pay;
    r.last    = 1'b0;
    release_queue.push_back(r);
  endfunction

  task automatic release_step(input logic is_end, input logic [31:0] id,
                              input logic [31:0] pay);
    int                         before_n;
    logic [31:0]                delta;
    logic                       any_parked;
    logic [srm_pkg::SLOT_W-1:0] slot;
    before_n = release_queue.size();
    if (done) begin
      queue_result(srm_pkg::KIND_REJECT, next_id, 32'd0);
    end else if (is_end) begin
      if (ends_count != srm_pkg::ENDS_MAX) ends_count++;
      if (ends_count >= sources) begin
        any_parked = 1'b0;
        foreach (parked[i]) any_parked |= parked[i];
        done = 1'b1;
        queue_result(any_parked ? srm_pkg::KIND_GAP : srm_pkg::KIND_DONE, next_id, 32'd0);
      end
    end else begin
      delta = id - next_id;
      slot  = id[srm_pkg::SLOT_W-1:0];
      if (delta == 32'd0) begin
        queue_result(srm_pkg::KIND_DATA, id, pay);
        next_id++;
      end else if (delta < srm_pkg::WINDOW) begin
        if (parked[slot]) begin
          queue_result(srm_pkg::KIND_REJECT, next_id, 32'd0);
        end else begin
          parked[slot]     = 1'b1;
          parked_pay[slot] = pay;
        end
      end else begin
        queue_result(srm_pkg::KIND_REJECT, next_id, 32'd0);
      end
      // walk the window while the next id is parked
      while (parked[next_id[srm_pkg::SLOT_W-1:0]]) begin
        slot = next_id[srm_pkg::SLOT_W-1:0];
        queue_result(srm_pkg::KIND_DATA, next_id, parked_pay[slot]);
        parked[slot] = 1'b0;
        next_id++;
      end
    end
    if (release_queue.size() > before_n)
      release_queue[release_queue.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      next_id    = 32'd0;
      foreach (parked[i]) parked[i] = 1'b0;
      ends_count = '0;
      sources    = srm_pkg::SRC_W'(1);
      done       = 1'b0;
      errors     = 0;
      release_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) sources = cfg_data;
      if (item_valid && item_ready) release_step(func, seq_id, payload);
      if (res_valid && res_ready) begin
        if (release_queue.size() == 0) begin
          errors++;
          $error("result transfer with nothing due: kind %0d out_id %h", kind, out_id);
        end else begin
          want = release_queue.pop_front();
          if (kind !== want.kind) begin
            errors++;
            $error("kind: expected %0d, got %0d", want.kind, kind);
          end
          if (out_id !== want.id) begin
            errors++;
            $error("out_id: expected %h, got %h", want.id, out_id);
          end
          if (out_payload !== want.payload) begin
            errors++;
            $error("out_payload: expected %h, got %h", want.payload, out_payload);
          end
          if (last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, last);
          end
        end
      end
    end
    pending = release_queue.size();
  end

endmodule

// ===== sim/testbench.sv =====
// top of the sequence reorder merger testbench: clock, reset, item and cfg stimulus,
// result back-pressure and the verdict
// depends on srm_pkg, srm_if, sequence_reorder_merger and srm_checker
`timescale 1ns / 1ps

module testbench;

  logic        clk = 1'b0;
  logic        rst;
  int          errors;
  int          pending;
  int          send_idle = 6;
  int          take_idle = 52;
  int          hold_reqs = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  logic [31:0] base      = 32'd0;
  int          ends_sent = 0;

  srm_in_if  items ();
  srm_out_if results ();
  srm_cfg_if cfg ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sequence_reorder_merger i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  srm_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (items.valid),
    .item_ready  (items.ready),
    .func        (items.func),
    .seq_id      (items.seq_id),
    .payload     (items.payload),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .kind        (results.kind),
    .out_id      (results.out_id),
    .out_payload (results.out_payload),
    .last        (results.last),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .cfg_data    (cfg.data),
    .errors      (errors),
    .pending     (pending)
  );

  // result back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(99) >= take_idle);
    end
  end

  task automatic offer(input logic is_end, input logic [31:0] id, input logic [31:0] pay);
    while ($urandom_range(99) < send_idle) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid   <= 1'b1;
    items.func    <= is_end;
    items.seq_id  <= id;
    items.payload <= pay;
    @(negedge clk);
    while (!items.ready) @(negedge clk);
    @(posedge clk);
    if (is_end) ends_sent++;
  endtask

  task automatic quiesce(input int tail);
    items.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_sources(input logic [srm_pkg::SRC_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(negedge clk);
    while (!cfg.ready) @(negedge clk);
    @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stray items: ids that must all be turned away without touching the window, or an end item
  task automatic offer_noise(input logic [31:0] order [$], input int sent_n);
    logic [31:0] id;
    case ($urandom_range(4))
      0: id = base - 32'd1 - $urandom_range(0, 1000);
      1: id = base + 32'd32 + $urandom_range(0, 1 << 20);
      2: id = (sent_n > 0) ? order[$urandom_range(sent_n - 1)] : base + 32'd40;
      3: begin
        id = $urandom;
        if (id - base < 32'd64) id[31] = ~id[31];
      end
      default: begin
        if (ends_sent < 30) begin
          offer(1'b1, $urandom, $urandom);
          return;
        end
        id = base + 32'd100;
      end
    endcase
    offer(1'b0, id, $urandom);
  endtask

  task automatic run_batch(input int k, input int noise_pct);
    logic [31:0] order [$];
    logic [31:0] tmp;
    int          j;
    for (int i = 0; i < k; i++) order.push_back(base + i);
    for (int i = k - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(99) < noise_pct) offer_noise(order, i);
      offer(1'b0, order[i], $urandom);
    end
    base += k;
  endtask

  task automatic run_phase(input int wanted, input int noise_pct);
    int sent;
    int k;
    sent = 0;
    while (sent < wanted) begin
      k = $urandom_range(1, srm_pkg::WINDOW);
      run_batch(k, noise_pct);
      sent += k;
    end
  endtask

  initial begin
    rst           <= 1'b1;
    items.valid   <= 1'b0;
    items.func    <= 1'b0;
    items.seq_id  <= 32'd0;
    items.payload <= 32'd0;
    cfg.valid     <= 1'b0;
    cfg.data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_sources(srm_pkg::SRC_W'(127));

    // in order, duplicate, behind, window edge and a full drain
    offer(1'b0, 32'd0, 32'd0);
    offer(1'b0, 32'd1, 32'hFFFF_FFFF);
    offer(1'b0, 32'd3, $urandom);
    offer(1'b0, 32'd3, $urandom);
    offer(1'b0, 32'd2, $urandom);
    offer(1'b0, 32'hFFFF_FFFF, $urandom);
    offer(1'b0, 32'd20, $urandom);
    offer(1'b0, 32'd19, 32'hFFFF_FFFF);
    for (int id = 18; id >= 5; id--) offer(1'b0, id, $urandom);
    offer(1'b0, 32'd4, 32'd0);
    offer(1'b1, $urandom, $urandom);
    base = 32'd20;

    run_phase(85, 15);
    quiesce(40);

    send_idle = 52;
    take_idle = 6;
    write_sources(srm_pkg::SRC_W'(64));
    run_phase(85, 15);
    quiesce(40);

    send_idle = 0;
    take_idle = 0;
    write_sources(srm_pkg::SRC_W'(100));
    hold_reqs++;
    run_phase(45, 10);
    quiesce(10);
    run_phase(45, 15);

    // leave a gap open half of the time, then complete the stream
    if ($urandom_range(1)) offer(1'b0, base + 32'd1 + $urandom_range(0, 14), $urandom);
    quiesce(40);
    write_sources(srm_pkg::SRC_W'(0));
    offer(1'b1, $urandom, $urandom);
    offer(1'b0, base, $urandom);
    offer(1'b1, $urandom, $urandom);
    offer(1'b0, $urandom, $urandom);

    quiesce(50);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
